>>> sv/osct_pkg.sv
// Shared types and constants for the order-statistic count tree unit.
package osct_pkg;

	// Key space and store limits
	localparam int VALUE_BITS = 10;
	localparam int CAPACITY   = 65535;

	localparam int LEAF_COUNT = 1 << VALUE_BITS;
	localparam int NODE_COUNT = (LEAF_COUNT << 1) - 1;
	localparam int ADDR_W     = VALUE_BITS + 1;
	localparam int LVL_W      = $clog2(VALUE_BITS + 1);

	// Field widths on the stream ports
	localparam int KEY_W   = 10;
	localparam int CNT_W   = 16;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 32;

	localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_KTH    = 2'd2,
		OP_RANK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RES_OK     = 2'd0,
		RES_ABSENT = 2'd1,
		RES_RANGE  = 2'd2,
		RES_FULL   = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic    clr_en;
		logic    load;
		logic    rd_leaf;
		logic    walk_step;
		logic    k_rd;
		logic    k_ev;
		logic    finish;
		status_t res_status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic  clr_last;
		logic  full;
		logic  k_oob;
		logic  leaf_zero;
		logic  out_free;
		mode_t mode;
	} sts_t;

endpackage

>>> sv/osct_ctrl.sv
// Sequencer for the count tree: clearing pass, decode, tree walks, result hand-off.
module osct_ctrl import osct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_DECODE = 8'b0000_0100,
		S_LCHK   = 8'b0000_1000,
		S_WALK   = 8'b0001_0000,
		S_KRD    = 8'b0010_0000,
		S_KEV    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} ctl_state_t;

	localparam logic [LVL_W-1:0] LVL_LAST_WALK = LVL_W'(VALUE_BITS);
	localparam logic [LVL_W-1:0] LVL_LAST_KTH  = LVL_W'(VALUE_BITS - 1);

	ctl_state_t       state_q, state_d;
	logic [LVL_W-1:0] lvl_q, lvl_d;
	status_t          res_q, res_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		lvl_d    = lvl_q;
		res_d    = res_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.res_status = res_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					lvl_d    = '0;
					res_d    = RES_OK;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.mode)
					OP_INSERT: begin
						if (sts.full) begin
							res_d   = RES_FULL;
							state_d = S_DONE;
						end else begin
							state_d = S_WALK;
						end
					end
					OP_ERASE: begin
						cmd.rd_leaf = 1'b1;
						state_d     = S_LCHK;
					end
					OP_KTH: begin
						if (sts.k_oob) begin
							res_d   = RES_RANGE;
							state_d = S_DONE;
						end else begin
							state_d = S_KRD;
						end
					end
					OP_RANK: state_d = S_WALK;
					default: state_d = S_DONE;
				endcase
			end
			S_LCHK: begin
				if (sts.leaf_zero) begin
					res_d   = RES_ABSENT;
					state_d = S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			// one read issued per level; the datapath finishes the last one in the following cycle
			S_WALK: begin
				if (lvl_q == LVL_LAST_WALK) begin
					lvl_d   = '0;
					state_d = S_DONE;
				end else begin
					cmd.walk_step = 1'b1;
					lvl_d = lvl_q + LVL_W'(1);
				end
			end
			S_KRD: begin
				cmd.k_rd = 1'b1;
				state_d  = S_KEV;
			end
			S_KEV: begin
				cmd.k_ev = 1'b1;
				if (lvl_q == LVL_LAST_KTH) begin
					lvl_d   = '0;
					state_d = S_DONE;
				end else begin
					lvl_d   = lvl_q + LVL_W'(1);
					state_d = S_KRD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			lvl_q   <= '0;
			res_q   <= RES_OK;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			res_q   <= res_d;
		end
	end

endmodule

>>> sv/osct_dp.sv
// Datapath: count memory, walk registers, running total and output register.
module osct_dp import osct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  mode_t              in_mode,
	input  logic [KEY_W-1:0]   in_key,
	input  logic [CNT_W-1:0]   in_order_index,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [CNT_W-1:0]   out_answer,
	output status_t            out_status,
	output logic [CNT_W-1:0]   out_total
);

	localparam logic [ADDR_W-1:0] LEAF_BASE = ADDR_W'(LEAF_COUNT - 1);
	localparam logic [ADDR_W-1:0] CLR_END   = ADDR_W'(NODE_COUNT - 1);

	// Count memory, one counter per tree node in heap order
	logic [CNT_W-1:0] mem [NODE_COUNT];
	logic [CNT_W-1:0] rdata_q;

	// Operation registers
	mode_t                mode_q;
	logic [VALUE_BITS-1:0] ksh_q;
	logic [CNT_W-1:0]     kidx_q;
	logic [ADDR_W-1:0]    node_q;
	logic [CNT_W-1:0]     acc_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CNT_W-1:0]     total_q;
	logic [ADDR_W-1:0]    clr_q;

	// Write-back stage of a walk
	logic              vld_s1;
	logic [ADDR_W-1:0] wa_s1;
	logic              bit_s1;

	logic [ADDR_W-1:0] left, child, leaf, ra, wa;
	logic [CNT_W-1:0]  wd, total_new, answer_new;
	logic              we, cur_bit, go_right;

	// Address generation
	always_comb begin
		cur_bit = ksh_q[VALUE_BITS-1];
		left    = {node_q[ADDR_W-2:0], 1'b1};
		child   = left + ADDR_W'(cur_bit);
		leaf    = LEAF_BASE + ADDR_W'(ksh_q);
		priority if (cmd.rd_leaf) begin
			ra = leaf;
		end else if (cmd.k_rd) begin
			ra = left;
		end else if (cmd.walk_step && mode_q == OP_RANK) begin
			ra = left;
		end else begin
			ra = child;
		end
	end

	// Write port: clearing pass or counter update on the walk path
	always_comb begin
		if (cmd.clr_en) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else begin
			we = vld_s1 && (mode_q == OP_INSERT || mode_q == OP_ERASE);
			wa = wa_s1;
			wd = (mode_q == OP_INSERT) ? rdata_q + CNT_W'(1) : rdata_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rdata_q <= mem[ra];
	end

	assign go_right = !(kidx_q < rdata_q);

	// Walk and query registers
	always_ff @(posedge clk) begin
		wa_s1  <= ra;
		bit_s1 <= cur_bit;
		if (cmd.load) begin
			mode_q <= in_mode;
			ksh_q  <= VALUE_BITS'(in_key);
			kidx_q <= in_order_index;
			node_q <= '0;
			acc_q  <= '0;
			val_q  <= '0;
		end else begin
			if (cmd.walk_step) begin
				node_q <= child;
				ksh_q  <= ksh_q << 1;
			end
			if (vld_s1 && mode_q == OP_RANK && bit_s1) acc_q <= acc_q + rdata_q;
			if (cmd.k_ev) begin
				val_q <= VALUE_BITS'({val_q, go_right});
				if (go_right) begin
					node_q <= left + ADDR_W'(1);
					kidx_q <= kidx_q - rdata_q;
				end else begin
					node_q <= left;
				end
			end
		end
	end

	// Result values
	always_comb begin
		total_new = total_q;
		if (cmd.res_status == RES_OK) begin
			if (mode_q == OP_INSERT) total_new = total_q + CNT_W'(1);
			if (mode_q == OP_ERASE)  total_new = total_q - CNT_W'(1);
		end
		answer_new = '0;
		if (mode_q == OP_RANK) answer_new = acc_q;
		if (mode_q == OP_KTH && cmd.res_status == RES_OK) answer_new = CNT_W'(val_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_answer <= answer_new;
			out_status <= cmd.res_status;
			out_total  <= total_new;
		end
	end

	// Control state: clear sweep, write-back valid, total, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			vld_s1    <= 1'b0;
			total_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clr_en) clr_q <= clr_q + ADDR_W'(1);
			vld_s1 <= cmd.walk_step;
			if (cmd.finish) begin
				total_q   <= total_new;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.clr_last  = (clr_q == CLR_END);
	assign sts.full      = (total_q >= CAP_LIMIT);
	assign sts.k_oob     = (kidx_q >= total_q);
	assign sts.leaf_zero = (rdata_q == '0);
	assign sts.out_free  = !out_valid || out_ready;
	assign sts.mode      = mode_q;

endmodule

>>> sv/order_statistic_count_trie_unit.sv
// Top level of the order-statistic count tree: multiset of keys with kth and rank queries.
//
//  channel   direction  tdata (low bit up)                 tuser
//  s_axis    in         key[9:0], order_index[25:10]       mode[1:0]
//  m_axis    out        answer[15:0], total[31:16]         status[1:0]
//
// One item at a time. Insert and rank walk every tree level; erase reads the leaf first
// and then walks; kth reads and evaluates each level in turn. A refused insert or an
// out-of-range kth goes straight to the result, as does an erase of an absent key.
// Each tree level costs one read of the single count memory, and kth must see a
// level's count before it can address the next one.
// After reset a clearing pass writes all NODE_COUNT counters with s_axis_tready low.
// A finished result waits in the output register; a new item is accepted meanwhile,
// and the unit stalls only when a second result is ready before the first is taken.
module order_statistic_count_trie_unit import osct_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // key[9:0], order_index[25:10], zero pad
	input  logic [1:0]          s_axis_tuser,  // mode[1:0]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // answer[15:0], total[31:16]
	output logic [1:0]          m_axis_tuser   // status[1:0]
);

	cmd_t             cmd;
	sts_t             sts;
	logic [CNT_W-1:0] answer, total;
	status_t          status;

	osct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	osct_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_mode        (mode_t'(s_axis_tuser)),
		.in_key         (s_axis_tdata[KEY_W-1:0]),
		.in_order_index (s_axis_tdata[KEY_W+CNT_W-1:KEY_W]),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_answer     (answer),
		.out_status     (status),
		.out_total      (total)
	);

	assign m_axis_tdata = {total, answer};
	assign m_axis_tuser = status;

`ifndef SYNTH
	// only one item in flight: ready drops right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while previous one still in work");

	// store never reports more elements than it may hold
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:16] <= CAP_LIMIT))
		else $error("total exceeds capacity");

	// refused insert only when the store is at capacity, answer is zero
	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == RES_FULL
		|-> m_axis_tdata[31:16] == CAP_LIMIT && m_axis_tdata[15:0] == '0)
		else $error("full status with total below capacity");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking bench for the order-statistic count tree unit: directed and random items.
module tb_top;
	import osct_pkg::*;

	// Expected outcome of one item
	typedef struct {
		logic [CNT_W-1:0] answer;
		status_t          status;
		logic [CNT_W-1:0] total;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;  // key[9:0], order_index[25:10], zero pad
	logic [1:0]          s_axis_tuser = '0;  // mode[1:0]
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;       // answer[15:0], total[31:16]
	logic [1:0]          m_axis_tuser;       // status[1:0]

	// Shadow copy of the count tree, heap order, root holds the total
	logic [CNT_W-1:0] node_count [NODE_COUNT];
	outcome_t         pending_outcomes [$];
	int               fail_count = 0;
	bit               source_gap_en = 1'b1;
	bit               sink_stall_en = 1'b1;

	order_statistic_count_trie_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// Add delta to every counter on the root-to-leaf path of key
	function automatic void bump_counts(input logic [KEY_W-1:0] key,
			input logic [CNT_W-1:0] delta);
		int node;
		int lvl;
		node = 0;
		node_count[0] = node_count[0] + delta;
		for (lvl = 0; lvl < VALUE_BITS; lvl++) begin
			node = 2 * node + 1 + int'(key[VALUE_BITS-1-lvl]);
			node_count[node] = node_count[node] + delta;
		end
	endfunction

	// Key of the element at zero-based position pos (pos must be below the total)
	function automatic logic [KEY_W-1:0] key_at(input int unsigned pos);
		int          node;
		int          lvl;
		int unsigned left_cnt;
		logic [KEY_W-1:0] found;
		node = 0;
		found = '0;
		for (lvl = 0; lvl < VALUE_BITS; lvl++) begin
			left_cnt = node_count[2 * node + 1];
			if (pos < left_cnt) begin
				node = 2 * node + 1;
			end else begin
				found[VALUE_BITS-1-lvl] = 1'b1;
				pos = pos - left_cnt;
				node = 2 * node + 2;
			end
		end
		return found;
	endfunction

	// Number of held elements strictly below key
	function automatic int unsigned count_below(input logic [KEY_W-1:0] key);
		int          node;
		int          lvl;
		int unsigned acc;
		node = 0;
		acc = 0;
		for (lvl = 0; lvl < VALUE_BITS; lvl++) begin
			if (key[VALUE_BITS-1-lvl])
				acc += node_count[2 * node + 1];
			node = 2 * node + 1 + int'(key[VALUE_BITS-1-lvl]);
		end
		return acc;
	endfunction

	// Apply one item to the shadow multiset and return what the unit must report
	function automatic outcome_t apply_op(input mode_t mode, input logic [KEY_W-1:0] key,
			input logic [CNT_W-1:0] idx);
		outcome_t    o;
		int unsigned held;
		held = node_count[0];
		o.answer = '0;
		o.status = RES_OK;
		case (mode)
			OP_INSERT: begin
				if (held >= CAPACITY || held >= 32'hFFFF)
					o.status = RES_FULL;
				else
					bump_counts(key, 16'd1);
			end
			OP_ERASE: begin
				if (node_count[LEAF_COUNT - 1 + int'(key)] == '0)
					o.status = RES_ABSENT;
				else
					bump_counts(key, 16'hFFFF);
			end
			OP_KTH: begin
				if (idx >= held)
					o.status = RES_RANGE;
				else
					o.answer = CNT_W'(key_at(idx));
			end
			default: begin
				o.answer = CNT_W'(count_below(key));
			end
		endcase
		o.total = node_count[0];
		return o;
	endfunction

	// Present one item, wait for the handshake, then record its expected outcome
	task automatic send_item(input mode_t mode, input logic [KEY_W-1:0] key,
			input logic [CNT_W-1:0] idx);
		if (source_gap_en) begin
			while ($urandom_range(99) < 22) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_DATA_W - KEY_W - CNT_W){1'b0}}, idx, key};
		s_axis_tuser  <= mode;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_outcomes.push_back(apply_op(mode, key, idx));
	endtask

	// Random key, half the time from a small pool so that repeats are common
	function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] pool [8]);
		if ($urandom_range(1))
			return pool[$urandom_range(7)];
		return KEY_W'($urandom_range(LEAF_COUNT - 1));
	endfunction

	// Queries on an empty store
	task automatic test_empty_store();
		send_item(OP_KTH, 10'd0, 16'd0);
		send_item(OP_KTH, 10'h3FF, 16'hFFFF);
		send_item(OP_ERASE, 10'd0, 16'd0);
		send_item(OP_ERASE, 10'h3FF, 16'hFFFF);
		send_item(OP_RANK, 10'h3FF, 16'd0);
		send_item(OP_RANK, 10'd0, 16'hFFFF);
	endtask

	// Each operation at the key and index extremes, duplicates included
	task automatic test_basic_ops();
		send_item(OP_INSERT, 10'd0, 16'hFFFF);
		send_item(OP_INSERT, 10'h3FF, 16'd0);
		send_item(OP_INSERT, 10'h3FF, 16'h5A5A);
		send_item(OP_INSERT, 10'h200, 16'hA5A5);
		send_item(OP_KTH, 10'h155, 16'd0);
		send_item(OP_KTH, 10'h2AA, 16'd2);
		send_item(OP_KTH, 10'd0, 16'd3);
		send_item(OP_KTH, 10'd0, 16'd4);
		send_item(OP_RANK, 10'd0, 16'd0);
		send_item(OP_RANK, 10'h3FF, 16'd0);
		send_item(OP_RANK, 10'h201, 16'hFFFF);
		send_item(OP_ERASE, 10'h3FF, 16'd0);
		send_item(OP_ERASE, 10'h3FF, 16'd0);
		send_item(OP_ERASE, 10'h3FF, 16'd0);
		send_item(OP_ERASE, 10'd1, 16'd0);
		send_item(OP_ERASE, 10'd0, 16'd0);
		send_item(OP_ERASE, 10'h200, 16'd0);
		send_item(OP_KTH, 10'd0, 16'd0);
	endtask

	// Mixed traffic on a small population, with a stretch in the middle free of source gaps and sink stalls
	task automatic test_random_mix();
		logic [KEY_W-1:0] pool [8];
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] idx;
		int unsigned      held;
		int               pick;
		pool[0] = '0;
		pool[1] = '1;
		for (int p = 2; p < 8; p++)
			pool[p] = KEY_W'($urandom_range(LEAF_COUNT - 1));
		for (int n = 0; n < 1300; n++) begin
			source_gap_en = !(n >= 500 && n < 800);
			sink_stall_en = source_gap_en;
			held = node_count[0];
			pick = $urandom_range(99);
			key  = pick_key(pool);
			idx  = CNT_W'($urandom_range(16'hFFFF));
			if (pick < 38) begin
				send_item(OP_INSERT, key, idx);
			end else if (pick < 60) begin
				if (held != 0 && $urandom_range(9) < 7)
					key = key_at($urandom_range(held - 1));
				send_item(OP_ERASE, key, idx);
			end else if (pick < 80) begin
				pick = $urandom_range(9);
				if (held != 0 && pick < 8)
					idx = CNT_W'($urandom_range(held - 1));
				else if (pick == 8)
					idx = CNT_W'(held);
				send_item(OP_KTH, key, idx);
			end else begin
				send_item(OP_RANK, key, idx);
			end
		end
		source_gap_en = 1'b1;
		sink_stall_en = 1'b1;
	endtask

	// Receiver side ready, stalling at random when enabled
	always @(posedge clk) begin
		if (sink_stall_en)
			m_axis_tready <= ($urandom_range(99) >= 22);
		else
			m_axis_tready <= 1'b1;
	end

	// Compare every accepted result with the oldest expectation
	always @(posedge clk) begin : check_outcomes
		outcome_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result answer %0d status %0d total %0d", $time,
					m_axis_tdata[15:0], m_axis_tuser, m_axis_tdata[31:16]);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (m_axis_tdata[15:0] !== want.answer) begin
					$display("%0t: answer expected %0d actual %0d", $time, want.answer,
						m_axis_tdata[15:0]);
					fail_count++;
				end
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[31:16] !== want.total) begin
					$display("%0t: total expected %0d actual %0d", $time, want.total,
						m_axis_tdata[31:16]);
					fail_count++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		foreach (node_count[i])
			node_count[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_store();
		test_basic_ops();
		test_random_mix();
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (pending_outcomes.size() == 0 && fail_count == 0)
			$display("order_statistic_count_trie_unit: match");
		else
			$display("order_statistic_count_trie_unit: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("order_statistic_count_trie_unit: mismatch");
		$finish;
	end

endmodule
